### rtl/core/pso_pkg.sv
// Package: shared types and constants for the particle swarm duty search.
`timescale 1ns / 1ps
`default_nettype none
package pso_pkg;
  localparam int NumParticlesDef = 5;
  localparam int PowerBitsDef    = 24;
  localparam logic [31:0] LfsrMask = 32'h8020_0003;
  localparam logic [16:0] OneQ15   = 17'd32768;

  typedef enum logic [2:0] {
    ST_SETUP       = 3'd0,
    ST_SET_DUTY    = 3'd1,
    ST_CHECK_POWER = 3'd2,
    ST_UPDATE      = 3'd3,
    ST_CONVERGE    = 3'd4,
    ST_GET_OPT     = 3'd5
  } stage_t;

  typedef enum logic [2:0] {
    REG_RES    = 3'd0,
    REG_INERT  = 3'd1,
    REG_PCOEF  = 3'd2,
    REG_GCOEF  = 3'd3,
    REG_LIMIT  = 3'd4,
    REG_THRESH = 3'd5,
    REG_SEED   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_CALL    = 2'd1,
    ACT_MEASURE = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_INIT, SQ_DUTY_MUL, SQ_DUTY_OUT, SQ_CHECK,
    SQ_DRAW1, SQ_DRAW2, SQ_MUL_W, SQ_MUL_R1, SQ_MUL_C1,
    SQ_MUL_R2, SQ_MUL_C2, SQ_SUM, SQ_CONV, SQ_OUT
  } seq_t;

  // One Galois LFSR step.
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    lfsr_step = s[0] ? ((s >> 1) ^ LfsrMask) : (s >> 1);
  endfunction
endpackage
`default_nettype wire

### rtl/core/pso_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module pso_mul (
  input  wire logic               clk,
  input  wire logic signed [32:0] a,
  input  wire logic signed [17:0] b,
  output logic signed [50:0]      p
);
  // Register one product per cycle
  always_ff @(posedge clk) begin
    p <= 51'(a * b);
  end
endmodule
`default_nettype wire

### rtl/core/pso_mppt_duty_search.sv
// Top level: particle swarm duty search for maximum power point tracking.
`timescale 1ns / 1ps
`default_nettype none
// One item advances the six-stage tracker by one step and gives one result.
// The block is busy for a step while a sequencer drives a single shared
// 33x18 multiplier: setup seeds one particle per sequencer state, and the
// update stage draws two random values, then runs five multiplier states
// and a sum for each particle in turn.
// The result sits in an output register; s_tready is high only while idle.
module pso_mppt_duty_search #(
  parameter int NUM_PARTICLES = pso_pkg::NumParticlesDef,
  parameter int POWER_BITS    = pso_pkg::PowerBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // permitted[0], power_meas[24:1], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // duty_valid[0], duty_value[16:1],
                                      // next_action[18:17], finished[19],
                                      // opt_valid[20], opt_power[44:21], pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import pso_pkg::*;

  localparam int IW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(NUM_PARTICLES - 1);

  // Configuration registers
  logic [4:0]  res_bits;
  logic [15:0] inertia, pcoef, gcoef;
  logic [7:0]  conv_limit;
  logic [23:0] conv_thresh;
  logic [31:0] seed;

  // Tracker state
  stage_t stage, stage_next;
  seq_t   seq, seq_next;
  logic [IW-1:0] pidx, widx;
  logic [16:0] pos   [NUM_PARTICLES];
  logic [16:0] bduty [NUM_PARTICLES];
  logic [23:0] bpow  [NUM_PARTICLES];
  logic signed [17:0] vel [NUM_PARTICLES];
  logic [16:0] sb_duty;
  logic [23:0] sb_pow, prev_pow;
  logic [7:0]  stable;
  logic [31:0] lfsr;

  // Latched item and working registers
  logic        in_perm;
  logic [23:0] in_pow;
  logic [15:0] r1, r2;
  logic signed [33:0] acc;

  // Result register
  logic        o_dvalid, o_fin, o_ovalid;
  logic [15:0] o_duty;
  action_t     o_act;
  logic [23:0] o_opow;

  // Shared multiplier operands
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;

  pso_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  logic [4:0]  rb;
  logic [15:0] dmax;
  logic [POWER_BITS-1:0] pw_mask;
  logic [23:0] pw_in;
  logic signed [17:0] dpos_b, dpos_g;
  logic [16:0] cur_pos, duty_src;
  logic [23:0] pdiff;
  logic [7:0]  stable_new;
  logic signed [50:0] trunc15, trunc30;
  logic signed [34:0] vsum, xsum;
  logic signed [17:0] vsat;
  logic [31:0] lfsr_adv;

  assign rb   = (res_bits == 5'd0) ? 5'd1 : ((res_bits > 5'd16) ? 5'd16 : res_bits);
  assign dmax = 16'((17'd1 << rb) - 17'd1);
  assign pw_mask = '1;
  assign pw_in = 24'(s_tdata[24:1] & 24'(pw_mask));
  assign cur_pos = pos[widx];
  assign dpos_b = 18'($signed({1'b0, bduty[widx]}) - $signed({1'b0, cur_pos}));
  assign dpos_g = 18'($signed({1'b0, sb_duty}) - $signed({1'b0, cur_pos}));
  assign duty_src = (stage == ST_CONVERGE) ? sb_duty : cur_pos;
  assign pdiff = (sb_pow >= prev_pow) ? sb_pow - prev_pow : prev_pow - sb_pow;
  assign stable_new = (pdiff < conv_thresh) ? ((stable == 8'd255) ? stable : stable + 8'd1)
                                            : 8'd0;
  assign lfsr_adv = lfsr_step(lfsr);
  // Truncate toward zero
  assign trunc15 = (mul_p < 0) ? -((-mul_p) >>> 15) : (mul_p >>> 15);
  assign trunc30 = (mul_p < 0) ? -((-mul_p) >>> 30) : (mul_p >>> 30);
  assign vsum = 35'(acc) + 35'(trunc30);
  assign vsat = (vsum > 35'sd131071) ? 18'sd131071 :
                (vsum < -35'sd131072) ? -18'sd131072 : 18'(vsum);
  assign xsum = 35'($signed({1'b0, cur_pos})) + 35'(vsat);

  assign s_tready  = (seq == SQ_IDLE) && !m_tvalid;
  assign cfg_ready = (seq == SQ_IDLE);

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (seq)
      SQ_DUTY_MUL: begin
        mul_a = 33'($signed({1'b0, duty_src}));
        mul_b = 18'($signed({2'b0, dmax - 16'd1}));
      end
      SQ_MUL_W: begin
        mul_a = 33'($signed({1'b0, inertia}));
        mul_b = vel[widx];
      end
      SQ_MUL_R1: begin
        mul_a = 33'($signed({1'b0, pcoef}));
        mul_b = 18'($signed({2'b0, r1}));
      end
      SQ_MUL_C1, SQ_MUL_C2: begin
        // Chain the coefficient-times-draw product straight from the multiplier
        mul_a = 33'(mul_p);
        mul_b = (seq == SQ_MUL_C1) ? dpos_b : dpos_g;
      end
      SQ_MUL_R2: begin
        mul_a = 33'($signed({1'b0, gcoef}));
        mul_b = 18'($signed({2'b0, r2}));
      end
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SQ_IDLE: if (s_tvalid && s_tready) begin
        seq_next = SQ_OUT;
        unique case (stage)
          ST_SETUP:       if (s_tdata[0]) seq_next = SQ_INIT;
          ST_SET_DUTY:    seq_next = SQ_DUTY_MUL;
          ST_CHECK_POWER: seq_next = SQ_CHECK;
          ST_UPDATE:      seq_next = SQ_DRAW1;
          ST_CONVERGE:    seq_next = SQ_CONV;
          default:        seq_next = SQ_OUT;
        endcase
      end
      SQ_INIT:     if (widx == LastIdx) seq_next = SQ_OUT;
      SQ_DUTY_MUL: seq_next = SQ_DUTY_OUT;
      SQ_DUTY_OUT: seq_next = SQ_OUT;
      SQ_CHECK:    seq_next = SQ_OUT;
      SQ_DRAW1:    seq_next = SQ_DRAW2;
      SQ_DRAW2:    seq_next = SQ_MUL_W;
      SQ_MUL_W:    seq_next = SQ_MUL_R1;
      SQ_MUL_R1:   seq_next = SQ_MUL_C1;
      SQ_MUL_C1:   seq_next = SQ_MUL_R2;
      SQ_MUL_R2:   seq_next = SQ_MUL_C2;
      SQ_MUL_C2:   seq_next = SQ_SUM;
      SQ_SUM:      seq_next = (widx == LastIdx) ? SQ_OUT : SQ_DRAW1;
      SQ_CONV:     seq_next = (stable_new >= conv_limit) ? SQ_DUTY_MUL : SQ_OUT;
      SQ_OUT:      seq_next = SQ_IDLE;
      default:     seq_next = SQ_IDLE;
    endcase
  end

  // Stage advance at the end of a step
  always_comb begin
    stage_next = stage;
    unique case (stage)
      ST_SETUP:       if (in_perm) stage_next = ST_SET_DUTY;
      ST_SET_DUTY:    stage_next = ST_CHECK_POWER;
      ST_CHECK_POWER: stage_next = (widx == LastIdx) ? ST_UPDATE : ST_SET_DUTY;
      ST_UPDATE:      stage_next = ST_CONVERGE;
      ST_CONVERGE:    stage_next = (stable >= conv_limit) ? ST_GET_OPT : ST_SET_DUTY;
      ST_GET_OPT:     stage_next = ST_SETUP;
      default:        stage_next = ST_SETUP;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SQ_IDLE;
      stage <= ST_SETUP;
      m_tvalid <= 1'b0;
    end else begin
      seq <= seq_next;
      if (seq == SQ_OUT) begin
        stage <= stage_next;
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Configuration and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      res_bits <= 5'd10; inertia <= 16'd19661; pcoef <= 16'd19661;
      gcoef <= 16'd32768; conv_limit <= 8'd5; conv_thresh <= 24'd256;
      seed <= 32'd1; lfsr <= 32'd1;
      pidx <= '0; stable <= '0;
      sb_duty <= '0; sb_pow <= '0; prev_pow <= '0;
      for (int i = 0; i < NUM_PARTICLES; i++) begin
        pos[i] <= '0; bduty[i] <= '0; bpow[i] <= '0; vel[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_RES:    res_bits <= cfg_data[4:0];
          REG_INERT:  inertia <= cfg_data[15:0];
          REG_PCOEF:  pcoef <= cfg_data[15:0];
          REG_GCOEF:  gcoef <= cfg_data[15:0];
          REG_LIMIT:  conv_limit <= cfg_data[7:0];
          REG_THRESH: conv_thresh <= cfg_data[23:0];
          REG_SEED: begin
            seed <= cfg_data;
            lfsr <= cfg_data;
          end
          default: ;
        endcase
      end
      unique case (seq)
        SQ_IDLE: begin
          // Latch the item only when it is accepted; hold the waiting result
          if (s_tvalid && s_tready) begin
            in_perm <= s_tdata[0];
            in_pow  <= pw_in;
            widx    <= (stage == ST_CHECK_POWER || stage == ST_SET_DUTY) ? pidx : '0;
            o_dvalid <= 1'b0; o_duty <= '0; o_act <= ACT_CALL;
            o_fin <= 1'b0; o_ovalid <= 1'b0; o_opow <= '0;
            if (stage == ST_SETUP && !s_tdata[0]) begin
              o_act <= ACT_SEND; o_fin <= 1'b1;
            end
            if (stage == ST_GET_OPT) begin
              o_act <= ACT_SEND; o_fin <= 1'b1; o_ovalid <= 1'b1; o_opow <= pw_in;
            end
          end
        end
        SQ_INIT: begin
          lfsr <= lfsr_adv;
          pos[widx] <= {2'b0, lfsr_adv[31:17]};
          bduty[widx] <= '0; bpow[widx] <= '0; vel[widx] <= '0;
          widx <= widx + IW'(1);
          pidx <= '0; sb_duty <= '0; sb_pow <= '0; prev_pow <= '0;
        end
        SQ_DUTY_OUT: begin
          o_dvalid <= 1'b1;
          o_act <= ACT_MEASURE;
          if (stage == ST_SET_DUTY && duty_src >= OneQ15) o_duty <= dmax;
          else if (stage == ST_SET_DUTY && duty_src == 17'd0) o_duty <= 16'd1;
          else o_duty <= 16'(mul_p >>> 15) + 16'd1;
        end
        SQ_CHECK: begin
          if (in_pow > bpow[widx]) begin
            bpow[widx] <= in_pow;
            bduty[widx] <= cur_pos;
            if (in_pow > sb_pow) begin
              sb_pow <= in_pow;
              sb_duty <= cur_pos;
            end
          end
          pidx <= (widx == LastIdx) ? '0 : widx + IW'(1);
        end
        SQ_DRAW1: begin
          lfsr <= lfsr_adv;
          r1 <= lfsr_adv[31:16];
        end
        SQ_DRAW2: begin
          lfsr <= lfsr_adv;
          r2 <= lfsr_adv[31:16];
        end
        SQ_MUL_R1: acc <= 34'(trunc15);
        SQ_MUL_R2: acc <= 34'(35'(acc) + 35'(trunc30));
        SQ_SUM: begin
          vel[widx] <= vsat;
          pos[widx] <= (xsum > 35'sd32768) ? OneQ15 : ((xsum < 0) ? 17'd0 : 17'(xsum));
          widx <= widx + IW'(1);
        end
        SQ_CONV: begin
          stable <= stable_new;
          prev_pow <= sb_pow;
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {3'b0, o_opow, o_ovalid, o_fin, o_act, o_duty, o_dvalid};

  // Keep unused state referenced
  logic unused_ok;
  assign unused_ok = ^{seed, s_tdata[31:25]};

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (seq != SQ_IDLE) |-> !s_tready) else $error("ready while busy");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !m_tvalid) else $error("stale result");
  a_opt_fin: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_ovalid) |-> o_fin) else $error("optimum without finish");
endmodule
`default_nettype wire

### tb/pso_mppt_duty_search_test.sv
// Testbench: stream-driven check of the particle swarm duty search against a predictor.
`timescale 1ns / 1ps
module pso_mppt_duty_search_test;
  import pso_pkg::*;

  localparam int NP = NumParticlesDef;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [23:0] opt_power;
    logic        opt_valid;
    logic        finished;
    logic [1:0]  next_action;
    logic [15:0] duty_value;
    logic        duty_valid;
  } step_out_t;

  // Swarm predictor with its own state and register copies; queues expected steps.
  class swarm_board;
    bit [4:0]  res_bits;
    bit [15:0] w_q15, c1_q14, c2_q14;
    bit [7:0]  conv_limit;
    bit [23:0] conv_thresh;
    stage_t    stg;
    int        pidx;
    bit [7:0]  stable_cnt;
    bit [31:0] lfsr_st;
    bit [15:0] pos[NP];
    bit [15:0] pbest_duty[NP];
    bit [23:0] pbest_pow[NP];
    longint    vel[NP];
    bit [15:0] gbest_duty;
    bit [23:0] gbest_pow, prev_gpow;
    step_out_t expected_q[$];
    int        errors;

    function void init();
      res_bits = 10; w_q15 = 19661; c1_q14 = 19661; c2_q14 = 32768;
      conv_limit = 5; conv_thresh = 256; lfsr_st = 1;
      stg = ST_SETUP; pidx = 0; stable_cnt = 0;
      foreach (pos[i]) begin
        pos[i] = 0; pbest_duty[i] = 0; pbest_pow[i] = 0; vel[i] = 0;
      end
      gbest_duty = 0; gbest_pow = 0; prev_gpow = 0; errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, bit [31:0] val);
      case (idx)
        REG_RES:    res_bits = val[4:0];
        REG_INERT:  w_q15 = val[15:0];
        REG_PCOEF:  c1_q14 = val[15:0];
        REG_GCOEF:  c2_q14 = val[15:0];
        REG_LIMIT:  conv_limit = val[7:0];
        REG_THRESH: conv_thresh = val[23:0];
        REG_SEED:   lfsr_st = val;
        default: ;
      endcase
    endfunction

    function longint next_rand();
      lfsr_st = lfsr_st[0] ? ((lfsr_st >> 1) ^ 32'h8020_0003) : (lfsr_st >> 1);
      return longint'(lfsr_st[31:16]);
    endfunction

    function longint tz_shift(longint x, int s);
      if (x < 0) return -((-x) >> s);
      return x >> s;
    endfunction

    function bit [15:0] to_duty(longint p, longint dmax);
      return 16'(1 + ((p * (dmax - 1)) >> 15));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the predicted tracker by one accepted item.
    function void note_item(bit permitted, bit [23:0] pw);
      step_out_t o;
      longint dmax, r1, r2, x, v, d;
      int b, k;
      o = '0;
      o.next_action = ACT_CALL;
      b = res_bits;
      if (b < 1) b = 1;
      if (b > 16) b = 16;
      dmax = (longint'(1) << b) - 1;
      case (stg)
        ST_SETUP: begin
          if (!permitted) begin
            o.next_action = ACT_SEND; o.finished = 1;
          end else begin
            for (int i = 0; i < NP; i++) begin
              pos[i] = 16'(next_rand() >> 1);
              pbest_duty[i] = 0; pbest_pow[i] = 0; vel[i] = 0;
            end
            pidx = 0; gbest_duty = 0; gbest_pow = 0; prev_gpow = 0;
            stg = ST_SET_DUTY;
          end
        end
        ST_SET_DUTY: begin
          k = (pidx < NP) ? pidx : NP - 1;
          if (pos[k] >= 16'd32768) o.duty_value = 16'(dmax);
          else if (pos[k] == 0) o.duty_value = 1;
          else o.duty_value = to_duty(pos[k], dmax);
          o.duty_valid = 1; o.next_action = ACT_MEASURE; stg = ST_CHECK_POWER;
        end
        ST_CHECK_POWER: begin
          k = (pidx < NP) ? pidx : NP - 1;
          if (pw > pbest_pow[k]) begin
            pbest_pow[k] = pw; pbest_duty[k] = pos[k];
            if (pw > gbest_pow) begin
              gbest_pow = pw; gbest_duty = pos[k];
            end
          end
          pidx = k + 1;
          if (pidx >= NP) begin
            pidx = 0; stg = ST_UPDATE;
          end else stg = ST_SET_DUTY;
        end
        ST_UPDATE: begin
          for (int i = 0; i < NP; i++) begin
            r1 = next_rand();
            r2 = next_rand();
            x = pos[i];
            v = tz_shift(longint'(w_q15) * vel[i], 15)
              + tz_shift(longint'(c1_q14) * r1 * (longint'(pbest_duty[i]) - x), 30)
              + tz_shift(longint'(c2_q14) * r2 * (longint'(gbest_duty) - x), 30);
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            vel[i] = v;
            x += v;
            if (x > 32768) x = 32768;
            if (x < 0) x = 0;
            pos[i] = 16'(x);
          end
          stg = ST_CONVERGE;
        end
        ST_CONVERGE: begin
          d = (gbest_pow >= prev_gpow) ? gbest_pow - prev_gpow : prev_gpow - gbest_pow;
          if (d < conv_thresh) begin
            if (stable_cnt < 255) stable_cnt++;
          end else stable_cnt = 0;
          prev_gpow = gbest_pow;
          if (stable_cnt >= conv_limit) begin
            o.duty_value = to_duty(gbest_duty, dmax);
            o.duty_valid = 1; o.next_action = ACT_MEASURE; stg = ST_GET_OPT;
          end else stg = ST_SET_DUTY;
        end
        ST_GET_OPT: begin
          o.opt_power = pw; o.opt_valid = 1; o.finished = 1;
          o.next_action = ACT_SEND; stg = ST_SETUP;
        end
        default: stg = ST_SETUP;
      endcase
      expected_q.push_back(o);
    endfunction

    // Compare one accepted result with the oldest expected step.
    function void check_result(logic [47:0] raw);
      step_out_t a, e;
      a = step_out_t'(raw[44:0]);
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", raw);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.duty_valid !== e.duty_valid) begin
        $error("duty_valid expected %0d actual %0d", e.duty_valid, a.duty_valid); errors++;
      end
      if (a.duty_value !== e.duty_value) begin
        $error("duty_value expected %0d actual %0d", e.duty_value, a.duty_value); errors++;
      end
      if (a.next_action !== e.next_action) begin
        $error("next_action expected %0d actual %0d", e.next_action, a.next_action); errors++;
      end
      if (a.finished !== e.finished) begin
        $error("finished expected %0d actual %0d", e.finished, a.finished); errors++;
      end
      if (a.opt_valid !== e.opt_valid) begin
        $error("opt_valid expected %0d actual %0d", e.opt_valid, a.opt_valid); errors++;
      end
      if (a.opt_power !== e.opt_power) begin
        $error("opt_power expected %0d actual %0d", e.opt_power, a.opt_power); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  swarm_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;
  int items_sent = 0;

  pso_mppt_duty_search u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random and check each accepted result.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // End the run on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one item and hold it until accepted; idle afterward at random.
  task automatic send_item(bit permitted, bit [23:0] pw);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, pw, permitted};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    board.note_item(permitted, pw);
    items_sent++;
    if ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drain the block, then write one register.
  task automatic write_reg(reg_idx_t idx, bit [31:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    board.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(bit [4:0] res, bit [15:0] w, bit [15:0] c1, bit [15:0] c2,
                          bit [7:0] lim, bit [23:0] th, bit [31:0] seed);
    write_reg(REG_RES, res);
    write_reg(REG_INERT, w);
    write_reg(REG_PCOEF, c1);
    write_reg(REG_GCOEF, c2);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_THRESH, th);
    write_reg(REG_SEED, seed);
  endtask

  // Tracking runs: mostly permitted, power steady at times so rounds converge.
  task automatic random_items(int n);
    bit [23:0] level;
    level = 24'($urandom());
    for (int i = 0; i < n; i++) begin
      if (items_sent == 600) begin
        send_idle = 52; recv_idle = 20;
      end else if (items_sent == 1200) begin
        send_idle = 0; recv_idle = 0;
      end
      case ($urandom_range(0, 9))
        0:       level = 24'($urandom());
        1, 2:    level = level + 24'($urandom_range(0, 300));
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) send_item($urandom_range(0, 19) != 0, 24'($urandom()));
      else send_item($urandom_range(0, 19) != 0, level);
    end
  endtask

  initial begin
    board.init();
    send_idle = 20;
    recv_idle = 52;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: not permitted, then one round at default settings with extreme powers.
    send_item(1'b0, 24'hFFFFFF);
    send_item(1'b1, 24'h000000);
    for (int i = 0; i < 10; i++) send_item(1'b1, (i % 2) ? 24'hFFFFFF : 24'h000001);
    send_item(1'b1, 24'h0);
    send_item(1'b1, 24'h0);

    // Smallest resolution, zero coefficients, immediate convergence.
    set_regs(5'd1, 16'd0, 16'd0, 16'd0, 8'd1, 24'hFFFFFF, 32'hFFFFFFFF);
    for (int i = 0; i < 12; i++) send_item(1'b1, 24'(i * 24'h155555));
    random_items(250);

    // Largest resolution and coefficients, never stable.
    set_regs(5'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 24'd0, $urandom() | 32'd1);
    random_items(350);

    // Mid settings with quick convergence.
    set_regs(5'($urandom_range(1, 16)), 16'($urandom()), 16'($urandom()), 16'($urandom()),
             8'($urandom_range(1, 4)), 24'($urandom_range(1000, 24'hFFFFFF)),
             $urandom() | 32'd1);
    random_items(400);

    set_regs(5'd10, 16'd19661, 16'd19661, 16'd32768, 8'd2, 24'h100000, 32'h1234_5679);
    random_items(350);

    set_regs(5'($urandom_range(1, 16)), 16'($urandom()), 16'($urandom()), 16'($urandom()),
             8'($urandom_range(1, 3)), 24'($urandom()), $urandom() | 32'd1);
    random_items(400);

    s_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
